// ===== rtl/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the contiguous segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package csa_pkg;

  localparam int KEY_W  = 16;
  localparam int SIZE_W = 25;
  localparam int BASE_W = 24;
  localparam int PID_W  = 32;
  localparam int ST_W   = 3;
  localparam int LIVE_W = 7;

  localparam logic [SIZE_W-1:0] POOL_CAP   = 25'h1000000;
  localparam logic [SIZE_W-1:0] POOL_RESET = 25'h0100000;

  typedef enum logic [1:0] {
    KIND_REQ,
    KIND_REL,
    KIND_PACK,
    KIND_INIT
  } csa_kind_t;

  typedef enum logic [1:0] {
    FIT_FIRST,
    FIT_BEST,
    FIT_WORST,
    FIT_NONE
  } csa_fit_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_ZERO,
    ST_KEY,
    ST_DUP,
    ST_NOSP,
    ST_NOTF,
    ST_FULL
  } csa_status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_RQN,
    S_NB1,
    S_NB2,
    S_MOVE,
    S_FIN,
    S_PACK,
    S_PFIN,
    S_DONE
  } csa_state_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [SIZE_W-1:0] len;
    logic              proc;
    logic [KEY_W-1:0]  key;
    logic [PID_W-1:0]  pid;
  } csa_entry_t;

  typedef struct packed {
    logic take;
    logic key_hit;
  } csa_match_t;

endpackage

`default_nettype wire

// ===== rtl/contiguous_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_segment_allocator
// Base-ordered segment table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// The segment table sits in a single-port-read memory and every request,
// release and compact walks it one entry per cycle through one compare unit.
// A valid request or release scans the table, then shifts it when a split or
// a merge needs that, then does its bookkeeping; a compact packs the live
// segments down and writes any free space as one trailing hole, and a
// reinitialize writes the initial hole. The walk is paced by the one memory
// read port. After reset the block writes the initial hole before it takes an item. Results wait in an output register.
`default_nettype none

module contiguous_segment_allocator #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [csa_pkg::KEY_W-1:0]    in_process_key,
  input  wire logic [csa_pkg::SIZE_W-1:0]   in_req_size,
  input  wire logic [1:0]                   in_fit,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [csa_pkg::ST_W-1:0]          out_status,
  output logic [csa_pkg::PID_W-1:0]         out_assigned_pid,
  output logic [csa_pkg::BASE_W-1:0]        out_seg_start,
  output logic [csa_pkg::SIZE_W-1:0]        out_seg_length,
  output logic [csa_pkg::LIVE_W-1:0]        out_live_processes,
  input  wire logic                         cfg_we,
  input  wire logic [csa_pkg::SIZE_W-1:0]   cfg_wdata
);
  import csa_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  csa_state_t state_r, state_nxt;

  csa_kind_t             kind_r, kind_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  csa_fit_t              fit_r, fit_nxt;
  logic [SIZE_W-1:0]     pool_size_r;
  logic [SIZE_W-1:0]     pool_act_r, pool_act_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [PID_W-1:0]      pid_r, pid_nxt;
  logic [CW-1:0]         tot_r, tot_nxt;
  logic [CW-1:0]         iss_r, iss_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic                  rv_r, rv_nxt;
  logic [CW-1:0]         rvi_r, rvi_nxt;
  logic                  up_r, up_nxt;
  logic                  dl2_r, dl2_nxt;
  logic                  have_r, have_nxt;
  logic                  dup_r, dup_nxt;
  logic [CW-1:0]         pk_r, pk_nxt;
  logic [BASE_W-1:0]     pb_r, pb_nxt;
  logic [SIZE_W-1:0]     pl_r, pl_nxt;
  logic                  lhole_r, lhole_nxt;
  logic [BASE_W-1:0]     lbase_r, lbase_nxt;
  logic [SIZE_W-1:0]     llen_r, llen_nxt;
  logic [CW-1:0]         nfill_r, nfill_nxt;
  logic [SIZE_W-1:0]     accb_r, accb_nxt;
  logic                  init_item_r, init_item_nxt;
  csa_status_t           res_st_r, res_st_nxt;
  logic [PID_W-1:0]      res_pid_r, res_pid_nxt;
  logic [BASE_W-1:0]     res_start_r, res_start_nxt;
  logic [SIZE_W-1:0]     res_len_r, res_len_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]       out_st_r, out_st_nxt;
  logic [PID_W-1:0]      out_pid_r, out_pid_nxt;
  logic [BASE_W-1:0]     out_start_r, out_start_nxt;
  logic [SIZE_W-1:0]     out_len_r, out_len_nxt;
  logic [LIVE_W-1:0]     out_live_r, out_live_nxt;

  logic                  mem_we;
  logic [CW-1:0]         wa_full, ra_full;
  csa_entry_t            mem_wd, rd_q;
  csa_match_t            match;

  logic                  acc, strm_done, split, full, nxt_ok, rq_merge, rhole;
  logic                  out_free;
  logic [CW-1:0]         pk1;
  logic [SIZE_W-1:0]     clamp;

  csa_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wa_full[IW-1:0]),
    .wdata (mem_wd),
    .raddr (ra_full[IW-1:0]),
    .rdata (rd_q)
  );

  csa_fit u_fit (
    .ent      (rd_q),
    .is_rel   (kind_r == KIND_REL),
    .key      (key_r),
    .size     (size_r),
    .fit      (fit_r),
    .have     (have_r),
    .pick_len (pl_r),
    .res      (match)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign strm_done = (left_r == '0) && !rv_r;
  assign pk1       = pk_r + ONE_C;
  assign nxt_ok    = pk1 < cnt_r;
  assign split     = pl_r != size_r;
  assign full      = cnt_r >= MAX_C;
  assign clamp     = (pool_size_r > POOL_CAP) ? POOL_CAP : pool_size_r;
  assign out_free  = !out_valid_r || out_ready;
  // next entry after the chosen hole continues the split remainder
  assign rq_merge  = !rd_q.proc && (({1'b0, pb_r} + pl_r) == {1'b0, rd_q.base});
  assign rhole     = nxt_ok && !rd_q.proc && (({1'b0, pb_r} + pl_r) == {1'b0, rd_q.base});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = init_item_r ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (acc) begin
          unique case (csa_kind_t'(in_kind))
            KIND_REQ:  state_nxt = ((in_req_size == '0) || (in_process_key == '0)) ?
                                   S_DONE : S_SCAN;
            KIND_REL:  state_nxt = (in_process_key == '0) ? S_DONE : S_SCAN;
            KIND_PACK: state_nxt = S_PACK;
            KIND_INIT: state_nxt = S_INIT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: if (strm_done) state_nxt = S_EVAL;
      S_EVAL: begin
        if (kind_r == KIND_REQ) begin
          priority if (dup_r || !have_r || (split && full) || !split) begin
            state_nxt = S_DONE;
          end else if (nxt_ok) begin
            state_nxt = S_RQN;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = have_r ? S_NB1 : S_DONE;
        end
      end
      S_RQN:  state_nxt = rq_merge ? S_DONE : S_MOVE;
      S_NB1:  state_nxt = S_NB2;
      S_NB2:  state_nxt = (lhole_r || rhole) ? S_MOVE : S_DONE;
      S_MOVE: if (strm_done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_PACK: if (strm_done) state_nxt = S_PFIN;
      S_PFIN: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    size_nxt      = size_r;
    fit_nxt       = fit_r;
    pool_act_nxt  = pool_act_r;
    cnt_nxt       = cnt_r;
    pid_nxt       = pid_r;
    tot_nxt       = tot_r;
    iss_nxt       = iss_r;
    left_nxt      = left_r;
    rv_nxt        = 1'b0;
    rvi_nxt       = rvi_r;
    up_nxt        = up_r;
    dl2_nxt       = dl2_r;
    have_nxt      = have_r;
    dup_nxt       = dup_r;
    pk_nxt        = pk_r;
    pb_nxt        = pb_r;
    pl_nxt        = pl_r;
    lhole_nxt     = lhole_r;
    lbase_nxt     = lbase_r;
    llen_nxt      = llen_r;
    nfill_nxt     = nfill_r;
    accb_nxt      = accb_r;
    init_item_nxt = init_item_r;
    res_st_nxt    = res_st_r;
    res_pid_nxt   = res_pid_r;
    res_start_nxt = res_start_r;
    res_len_nxt   = res_len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_st_nxt    = out_st_r;
    out_pid_nxt   = out_pid_r;
    out_start_nxt = out_start_r;
    out_len_nxt   = out_len_r;
    out_live_nxt  = out_live_r;
    mem_we        = 1'b0;
    wa_full       = '0;
    mem_wd        = '0;
    ra_full       = iss_r;

    // streaming walk over the table, one read issued per cycle
    if ((state_r == S_SCAN) || (state_r == S_PACK) || (state_r == S_MOVE)) begin
      if (left_r != '0) begin
        iss_nxt  = up_r ? (iss_r - ONE_C) : (iss_r + ONE_C);
        left_nxt = left_r - ONE_C;
        rv_nxt   = 1'b1;
        rvi_nxt  = iss_r;
      end
    end

    unique case (state_r)
      S_INIT: begin
        mem_we        = 1'b1;
        mem_wd.len    = clamp;
        pool_act_nxt  = clamp;
        cnt_nxt       = ONE_C;
        pid_nxt       = '0;
        tot_nxt       = '0;
        res_len_nxt   = clamp;
        init_item_nxt = 1'b0;
      end
      S_IDLE: begin
        if (acc) begin
          kind_nxt      = csa_kind_t'(in_kind);
          key_nxt       = in_process_key;
          size_nxt      = in_req_size;
          fit_nxt       = csa_fit_t'(in_fit);
          res_st_nxt    = ST_OK;
          res_pid_nxt   = '0;
          res_start_nxt = '0;
          res_len_nxt   = '0;
          have_nxt      = 1'b0;
          dup_nxt       = 1'b0;
          iss_nxt       = '0;
          left_nxt      = cnt_r;
          up_nxt        = 1'b0;
          nfill_nxt     = '0;
          accb_nxt      = '0;
          init_item_nxt = 1'b1;
          if (csa_kind_t'(in_kind) == KIND_REQ) begin
            if (in_req_size == '0) begin
              res_st_nxt = ST_ZERO;
            end else if (in_process_key == '0) begin
              res_st_nxt = ST_KEY;
            end
          end else if (csa_kind_t'(in_kind) == KIND_REL) begin
            if (in_process_key == '0) begin
              res_st_nxt = ST_NOTF;
            end
          end
        end
      end
      S_SCAN: begin
        if (rv_r) begin
          dup_nxt = dup_r || match.key_hit;
          if (match.take) begin
            have_nxt = 1'b1;
            pk_nxt   = rvi_r;
            pb_nxt   = rd_q.base;
            pl_nxt   = rd_q.len;
          end
        end
      end
      S_EVAL: begin
        if (kind_r == KIND_REQ) begin
          priority if (dup_r) begin
            res_st_nxt = ST_DUP;
          end else if (!have_r) begin
            res_st_nxt = ST_NOSP;
          end else if (split && full) begin
            res_st_nxt = ST_FULL;
          end else begin
            pid_nxt       = pid_r + 1'b1;
            tot_nxt       = tot_r + ONE_C;
            mem_we        = 1'b1;
            wa_full       = pk_r;
            mem_wd.base   = pb_r;
            mem_wd.len    = size_r;
            mem_wd.proc   = 1'b1;
            mem_wd.key    = key_r;
            mem_wd.pid    = pid_r + 1'b1;
            res_pid_nxt   = pid_r + 1'b1;
            res_start_nxt = pb_r;
            res_len_nxt   = size_r;
            ra_full       = pk1;
          end
        end else begin
          if (!have_r) begin
            res_st_nxt = ST_NOTF;
          end else begin
            tot_nxt       = tot_r - ONE_C;
            res_start_nxt = pb_r;
            res_len_nxt   = pl_r;
            ra_full       = pk_r - ONE_C;
          end
        end
      end
      S_RQN: begin
        if (rq_merge) begin
          mem_we      = 1'b1;
          wa_full     = pk1;
          mem_wd.base = BASE_W'(pb_r + size_r[BASE_W-1:0]);
          mem_wd.len  = (pl_r - size_r) + rd_q.len;
        end else begin
          iss_nxt  = cnt_r - ONE_C;
          left_nxt = cnt_r - pk1;
          up_nxt   = 1'b1;
        end
      end
      S_NB1: begin
        lhole_nxt = (pk_r != '0) && !rd_q.proc &&
                    (({1'b0, rd_q.base} + rd_q.len) == {1'b0, pb_r});
        lbase_nxt = rd_q.base;
        llen_nxt  = rd_q.len;
        ra_full   = pk1;
      end
      S_NB2: begin
        mem_we  = 1'b1;
        up_nxt  = 1'b0;
        dl2_nxt = 1'b0;
        priority if (lhole_r && rhole) begin
          wa_full     = pk_r - ONE_C;
          mem_wd.base = lbase_r;
          mem_wd.len  = llen_r + pl_r + rd_q.len;
          iss_nxt     = pk_r + TWO_C;
          left_nxt    = cnt_r - pk_r - TWO_C;
          dl2_nxt     = 1'b1;
        end else if (lhole_r) begin
          wa_full     = pk_r - ONE_C;
          mem_wd.base = lbase_r;
          mem_wd.len  = llen_r + pl_r;
          iss_nxt     = pk1;
          left_nxt    = cnt_r - pk1;
        end else if (rhole) begin
          wa_full     = pk_r;
          mem_wd.base = pb_r;
          mem_wd.len  = pl_r + rd_q.len;
          iss_nxt     = pk_r + TWO_C;
          left_nxt    = cnt_r - pk_r - TWO_C;
        end else begin
          wa_full     = pk_r;
          mem_wd.base = pb_r;
          mem_wd.len  = pl_r;
        end
      end
      S_MOVE: begin
        if (rv_r) begin
          mem_we  = 1'b1;
          wa_full = up_r ? (rvi_r + ONE_C) : (rvi_r - (dl2_r ? TWO_C : ONE_C));
          mem_wd  = rd_q;
        end
      end
      S_FIN: begin
        if (kind_r == KIND_REQ) begin
          mem_we      = 1'b1;
          wa_full     = pk1;
          mem_wd.base = BASE_W'(pb_r + size_r[BASE_W-1:0]);
          mem_wd.len  = pl_r - size_r;
          cnt_nxt     = cnt_r + ONE_C;
        end else begin
          cnt_nxt = cnt_r - (dl2_r ? TWO_C : ONE_C);
        end
      end
      S_PACK: begin
        if (rv_r && rd_q.proc) begin
          mem_we      = 1'b1;
          wa_full     = nfill_r;
          mem_wd      = rd_q;
          mem_wd.base = accb_r[BASE_W-1:0];
          accb_nxt    = accb_r + rd_q.len;
          nfill_nxt   = nfill_r + ONE_C;
        end
      end
      S_PFIN: begin
        if ((pool_act_r > accb_r) && (nfill_r < MAX_C)) begin
          mem_we        = 1'b1;
          wa_full       = nfill_r;
          mem_wd.base   = accb_r[BASE_W-1:0];
          mem_wd.len    = pool_act_r - accb_r;
          cnt_nxt       = nfill_r + ONE_C;
          res_start_nxt = accb_r[BASE_W-1:0];
          res_len_nxt   = pool_act_r - accb_r;
        end else begin
          cnt_nxt = nfill_r;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_pid_nxt   = res_pid_r;
          out_start_nxt = res_start_r;
          out_len_nxt   = res_len_r;
          out_live_nxt  = LIVE_W'(tot_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pool_size_r <= POOL_RESET;
      rv_r        <= 1'b0;
      left_r      <= '0;
      init_item_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= ONE_C;
      pid_r       <= '0;
      tot_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        pool_size_r <= cfg_wdata;
      end
      rv_r        <= rv_nxt;
      left_r      <= left_nxt;
      init_item_r <= init_item_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pid_r       <= pid_nxt;
      tot_r       <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    size_r      <= size_nxt;
    fit_r       <= fit_nxt;
    pool_act_r  <= pool_act_nxt;
    iss_r       <= iss_nxt;
    rvi_r       <= rvi_nxt;
    up_r        <= up_nxt;
    dl2_r       <= dl2_nxt;
    have_r      <= have_nxt;
    dup_r       <= dup_nxt;
    pk_r        <= pk_nxt;
    pb_r        <= pb_nxt;
    pl_r        <= pl_nxt;
    lhole_r     <= lhole_nxt;
    lbase_r     <= lbase_nxt;
    llen_r      <= llen_nxt;
    nfill_r     <= nfill_nxt;
    accb_r      <= accb_nxt;
    res_st_r    <= res_st_nxt;
    res_pid_r   <= res_pid_nxt;
    res_start_r <= res_start_nxt;
    res_len_r   <= res_len_nxt;
    out_st_r    <= out_st_nxt;
    out_pid_r   <= out_pid_nxt;
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
    out_live_r  <= out_live_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_st_r;
  assign out_assigned_pid   = out_pid_r;
  assign out_seg_start      = out_start_r;
  assign out_seg_length     = out_len_r;
  assign out_live_processes = out_live_r;

endmodule

`default_nettype wire

// ===== rtl/csa_mem.sv =====
// ----------------------------------------------------------------------------
// csa_mem
// Segment table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire csa_pkg::csa_entry_t wdata,
  input  wire logic [AW-1:0]       raddr,
  output csa_pkg::csa_entry_t      rdata
);
  import csa_pkg::*;

  csa_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/csa_fit.sv =====
// ----------------------------------------------------------------------------
// csa_fit
// Compare unit applied to one table entry per cycle: hole fit choice and
// process key match.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_fit (
  input  wire csa_pkg::csa_entry_t         ent,
  input  wire logic                        is_rel,
  input  wire logic [csa_pkg::KEY_W-1:0]   key,
  input  wire logic [csa_pkg::SIZE_W-1:0]  size,
  input  wire csa_pkg::csa_fit_t           fit,
  input  wire logic                        have,
  input  wire logic [csa_pkg::SIZE_W-1:0]  pick_len,
  output csa_pkg::csa_match_t              res
);
  import csa_pkg::*;

  logic qual;

  always_comb begin
    qual        = !ent.proc && (ent.len >= size);
    res.key_hit = ent.proc && (ent.key == key);
    if (is_rel) begin
      res.take = res.key_hit && !have;
    end else begin
      unique case (fit)
        FIT_FIRST: res.take = qual && !have;
        FIT_BEST:  res.take = qual && (!have || (ent.len < pick_len));
        FIT_WORST: res.take = qual && (!have || (ent.len > pick_len));
        FIT_NONE:  res.take = 1'b0;
        default:   res.take = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csa_chk.sv =====
// ----------------------------------------------------------------------------
// csa_chk
// Port-level checks of the segment allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [1:0]                   in_kind,
  input wire logic [csa_pkg::KEY_W-1:0]    in_process_key,
  input wire logic [csa_pkg::SIZE_W-1:0]   in_req_size,
  input wire logic [1:0]                   in_fit,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [csa_pkg::ST_W-1:0]     out_status,
  input wire logic [csa_pkg::PID_W-1:0]    out_assigned_pid,
  input wire logic [csa_pkg::BASE_W-1:0]   out_seg_start,
  input wire logic [csa_pkg::SIZE_W-1:0]   out_seg_length,
  input wire logic [csa_pkg::LIVE_W-1:0]   out_live_processes,
  input wire logic                         cfg_we,
  input wire logic [csa_pkg::SIZE_W-1:0]   cfg_wdata
);
  import csa_pkg::*;

  // one item in flight: taking an item closes the input
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after an item was taken");

  // any failed item carries no pid and no segment
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_assigned_pid == '0) && (out_seg_start == '0) && (out_seg_length == '0)))
    else $error("error result with nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_assigned_pid) && $stable(out_seg_length)))
    else $error("stalled result changed");

endmodule

bind contiguous_segment_allocator csa_chk u_csa_chk (.*);

`default_nettype wire
